>>> hdl/irpm_pkg.sv
package irpm_pkg;

  localparam int NumPatterns = 256;
  localparam int MaxSlots    = 64;
  localparam int MaxHits     = 64;

  localparam int PatW   = $clog2(NumPatterns);
  localparam int SlotW  = $clog2(MaxSlots);
  localparam int HitW   = $clog2(MaxHits + 1);
  localparam int CountW = 9;

  localparam logic [1:0] ModeEvent    = 2'd0;
  localparam logic [1:0] ModeWrSlot   = 2'd1;
  localparam logic [1:0] ModeWrCode   = 2'd2;

  localparam logic [1:0] KindSpace    = 2'd0;
  localparam logic [1:0] KindPulse    = 2'd1;
  localparam logic [1:0] KindTimeout  = 2'd2;
  localparam logic [1:0] KindIgnored  = 2'd3;

  localparam logic [2:0] RegMargin    = 3'd0;
  localparam logic [2:0] RegProtocol  = 3'd1;
  localparam logic [2:0] RegTrail     = 3'd2;
  localparam logic [2:0] RegMaxLength = 3'd3;
  localparam logic [2:0] RegPatCount  = 3'd4;

  typedef struct packed {
    logic [1:0]  mode;
    logic [1:0]  event_kind;
    logic [23:0] duration;
    logic [7:0]  pattern_index;
    logic [5:0]  slot_index;
    logic [31:0] table_value;
  } in_item_t;

  typedef struct packed {
    logic [31:0] scancode;
    logic [7:0]  protocol;
    logic        last_hit;
    logic        hits_dropped;
  } out_item_t;

endpackage

>>> hdl/ir_pulse_space_pattern_matcher_top.sv
// table writes, ignored items and non-ending events past the length limit
// are taken without a walk; any other timing event holds the input while
// it walks the patterns, all 256 when it ends a sequence, since that walk
// also clears all 256 mismatch bits; one item at a time; a stalled output
// item pauses the walk, and the last result goes out from the emit state
// reset: synchronous; registers return to defaults and a clearing walk over
// the mismatch bits runs while the input stalls; pattern tables are undefined
module ir_pulse_space_pattern_matcher_top import irpm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_item,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_item,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data
);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_EMIT} state_t;

  logic [15:0] margin;
  logic [7:0]  protocol_code;
  logic [23:0] end_gap;
  logic [6:0]  len_limit;
  logic [8:0]  pattern_count;

  state_t       state;
  logic [6:0]   position;
  logic         ends;
  logic [23:0]  dur;
  logic [SlotW-1:0] pos_slot;
  logic         pos_past;
  logic [CountW-1:0] limit;      // patterns that may hit or get marked
  logic [CountW-1:0] scan_end;   // patterns walked
  logic [CountW-1:0] rd_cnt;     // next pattern to read
  logic         p_valid;         // read issued on the last scan step
  logic [PatW-1:0] p_idx;
  logic [HitW-1:0] hits;
  logic         dropped;
  logic         pend_valid;
  logic [31:0]  pend_code;

  // memories
  logic [15:0] dur_mem [NumPatterns*MaxSlots];
  logic [31:0] code_mem [NumPatterns];
  logic        mis_mem [NumPatterns];
  logic [15:0] dur_q;
  logic [31:0] code_q;
  logic        mis_q;
  logic        mis_we;
  logic        mis_wd;
  logic [PatW-1:0] rd_pat;
  logic        rd_en;

  logic accept;
  logic out_free, scan_go, emit_go;
  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign rd_pat   = rd_cnt[PatW-1:0];
  assign out_free = !out_valid || !out_stall;
  assign scan_go  = (state == S_SCAN) && out_free;
  assign emit_go  = (state == S_EMIT) && out_free;
  assign rd_en    = scan_go && (rd_cnt < scan_end);

  logic is_event, ev_ends, quiet;
  logic [CountW-1:0] lim_now;
  assign is_event = accept && in_item.mode == ModeEvent && in_item.event_kind != KindIgnored;
  assign ev_ends  = in_item.event_kind != KindPulse && in_item.duration >= end_gap;
  assign quiet    = position >= len_limit;
  assign lim_now  = (pattern_count > CountW'(NumPatterns)) ? CountW'(NumPatterns)
                                                           : pattern_count;

  always_ff @(posedge clk) begin
    if (accept && in_item.mode == ModeWrSlot)
      dur_mem[{in_item.pattern_index[PatW-1:0], in_item.slot_index[SlotW-1:0]}]
        <= in_item.table_value[15:0];
    if (accept && in_item.mode == ModeWrCode)
      code_mem[in_item.pattern_index[PatW-1:0]] <= in_item.table_value;
    if (rd_en) begin
      dur_q  <= dur_mem[{rd_pat, pos_slot}];
      code_q <= code_mem[rd_pat];
      mis_q  <= mis_mem[rd_pat];
    end
    if (mis_we)
      mis_mem[p_idx] <= mis_wd;
  end

  // evaluation of the pattern read on the last scan step
  logic        in_lim, ended, win, hit, hit_keep, out_load;
  logic [16:0] lo, hi;
  assign in_lim   = {1'b0, p_idx} < limit;
  assign ended    = pos_past || dur_q == 16'd0;
  assign lo       = (dur_q > margin) ? {1'b0, dur_q - margin} : 17'd0;
  assign hi       = {1'b0, dur_q} + {1'b0, margin};
  assign win      = (dur > {7'd0, lo}) && (dur < {7'd0, hi});
  assign hit      = scan_go && p_valid && ends && in_lim && !mis_q && ended;
  assign hit_keep = hit && (hits != HitW'(MaxHits));
  // an ending walk clears every bit, other walks only set them
  assign mis_we   = scan_go && p_valid && (ends || (!mis_q && (ended || !win)));
  assign mis_wd   = !ends;
  // the newest hit waits in pend until the next one shows it is not the last
  assign out_load = pend_valid && (hit_keep || emit_go);

  always_ff @(posedge clk) begin
    if (rst) begin
      margin <= 16'd200; protocol_code <= 8'd68; end_gap <= 24'd1000;
      len_limit <= 7'd1; pattern_count <= 9'd0;
      // start with a clearing walk over all mismatch bits
      state <= S_SCAN; position <= '0; ends <= 1'b1;
      limit <= '0; scan_end <= CountW'(NumPatterns); rd_cnt <= '0;
      p_valid <= 1'b0; out_valid <= 1'b0; hits <= '0; dropped <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          RegMargin:    margin <= cfg_data[15:0];
          RegProtocol:  protocol_code <= cfg_data[7:0];
          RegTrail:     end_gap <= cfg_data;
          RegMaxLength: len_limit <= cfg_data[6:0];
          RegPatCount:  pattern_count <= cfg_data[8:0];
          default: ;
        endcase
      end
      if (out_load) begin
        out_valid <= 1'b1;
        out_item.scancode     <= pend_code;
        out_item.protocol     <= protocol_code;
        out_item.last_hit     <= emit_go;
        out_item.hits_dropped <= emit_go && dropped;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          // past the length limit only an ending space or timeout matters, and it emits nothing
          if (is_event && (!quiet || ev_ends)) begin
            state    <= S_SCAN;
            ends     <= ev_ends;
            dur      <= in_item.duration;
            limit    <= quiet ? '0 : lim_now;
            scan_end <= ev_ends ? CountW'(NumPatterns) : lim_now;
            rd_cnt   <= '0;
            hits     <= '0;
            dropped  <= 1'b0;
          end
        end
        S_SCAN: begin
          if (scan_go) begin
            p_valid <= rd_en;
            p_idx   <= rd_pat;
            if (rd_en) rd_cnt <= rd_cnt + 1'b1;
            if (hit_keep) begin
              pend_valid <= 1'b1;
              pend_code  <= code_q;
              hits       <= hits + 1'b1;
            end else if (hit) begin
              dropped <= 1'b1;
            end
            if (!p_valid && !rd_en) state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (emit_go) begin
            pend_valid <= 1'b0;
            if (ends) begin
              position <= '0;
            end else begin
              position <= position + 7'd1;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign pos_slot = position[SlotW-1:0];
  assign pos_past = position >= 7'(MaxSlots);

endmodule

>>> hdl/irpm_checker.sv
module irpm_checker import irpm_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_item
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("output item changed while stalled");

  // reset starts the clearing walk with the input held off
  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid && in_stall)
    else $error("wrong state after reset");

  a_drop_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.hits_dropped |-> out_item.last_hit)
    else $error("drop flag without last flag");

  a_no_take_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_item.last_hit |-> in_stall)
    else $error("input accepted mid burst");

endmodule

bind ir_pulse_space_pattern_matcher_top irpm_checker u_irpm_checker (
  .clk(clk), .rst(rst), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
);

>>> tb/ir_pulse_space_pattern_matcher_checker.sv
`timescale 1ns / 1ps

module ir_pulse_space_pattern_matcher_checker import irpm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  in_item_t    in_item,
  input  logic        out_valid,
  input  logic        out_stall,
  input  out_item_t   out_item,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data,
  output int          pending,
  output int          errors
);

  logic [15:0] margin_r;
  logic [7:0]  proto_r;
  logic [23:0] trail_r;
  logic [6:0]  maxlen_r;
  logic [8:0]  patcnt_r;

  logic [6:0]  pos_r;
  logic        miss_r [NumPatterns];
  logic [15:0] slot_mem [NumPatterns][MaxSlots];
  logic [31:0] code_mem [NumPatterns];

  out_item_t   key_q [$];
  int          err_cnt = 0;

  assign errors = err_cnt;

  function automatic bit near(logic [23:0] d, logic [15:0] r);
    int unsigned lo;
    int unsigned hi;
    lo = (r > margin_r) ? int'(r) - int'(margin_r) : 0;
    hi = int'(r) + int'(margin_r);
    return (d > lo) && (d < hi);
  endfunction

  task automatic clear_seq();
    pos_r = '0;
    foreach (miss_r[i]) miss_r[i] = 1'b0;
  endtask

  // walk the pattern table for one item and queue the key events it causes
  task automatic match_item(in_item_t it);
    int unsigned lim;
    logic [15:0] slot_d;
    bit ends;
    int hits;
    bit dropped;
    out_item_t k;
    hits = 0;
    dropped = 0;
    case (it.mode)
      ModeWrSlot: slot_mem[it.pattern_index][it.slot_index] = it.table_value[15:0];
      ModeWrCode: code_mem[it.pattern_index] = it.table_value;
      ModeEvent: begin
        if (it.event_kind != KindIgnored) begin
          ends = (it.event_kind != KindPulse) && (it.duration >= trail_r);
          lim = (patcnt_r > NumPatterns) ? NumPatterns : patcnt_r;
          if (pos_r >= maxlen_r) begin
            if (ends) clear_seq();
          end else if (ends) begin
            for (int i = 0; i < lim; i++) begin
              slot_d = (pos_r < MaxSlots) ? slot_mem[i][pos_r] : '0;
              if (!miss_r[i] && slot_d == 0) begin
                if (hits >= MaxHits) begin
                  dropped = 1;
                end else begin
                  k.scancode = code_mem[i];
                  k.protocol = proto_r;
                  k.last_hit = 1'b0;
                  k.hits_dropped = 1'b0;
                  key_q.push_back(k);
                  hits++;
                end
              end
            end
            if (hits > 0) begin
              key_q[key_q.size() - 1].last_hit = 1'b1;
              key_q[key_q.size() - 1].hits_dropped = dropped;
            end
            clear_seq();
          end else begin
            for (int i = 0; i < lim; i++) begin
              slot_d = (pos_r < MaxSlots) ? slot_mem[i][pos_r] : '0;
              if (!miss_r[i] && (slot_d == 0 || !near(it.duration, slot_d)))
                miss_r[i] = 1'b1;
            end
            pos_r = pos_r + 7'd1;
          end
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      margin_r = 16'd200;
      proto_r = 8'd68;
      trail_r = 24'd1000;
      maxlen_r = 7'd1;
      patcnt_r = 9'd0;
      clear_seq();
      key_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          RegMargin:    margin_r = cfg_data[15:0];
          RegProtocol:  proto_r = cfg_data[7:0];
          RegTrail:     trail_r = cfg_data;
          RegMaxLength: maxlen_r = cfg_data[6:0];
          RegPatCount:  patcnt_r = cfg_data[8:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) match_item(in_item);
      if (out_valid && !out_stall) begin
        if (key_q.size() == 0) begin
          if (err_cnt < 10)
            $display("%0t: unexpected key event scancode=%h protocol=%h last=%b dropped=%b",
                     $time, out_item.scancode, out_item.protocol, out_item.last_hit,
                     out_item.hits_dropped);
          err_cnt++;
        end else begin
          want = key_q.pop_front();
          if (out_item.scancode !== want.scancode || out_item.protocol !== want.protocol ||
              out_item.last_hit !== want.last_hit ||
              out_item.hits_dropped !== want.hits_dropped) begin
            if (err_cnt < 10)
              $display("%0t: key event mismatch exp %h/%h/%b/%b got %h/%h/%b/%b", $time,
                       want.scancode, want.protocol, want.last_hit, want.hits_dropped,
                       out_item.scancode, out_item.protocol, out_item.last_hit,
                       out_item.hits_dropped);
            err_cnt++;
          end
        end
      end
    end
    pending <= key_q.size();
  end

endmodule

>>> tb/ir_pulse_space_pattern_matcher_top_test.sv
`timescale 1ns / 1ps

module ir_pulse_space_pattern_matcher_top_test;
  import irpm_pkg::*;

  localparam logic [1:0] ModeUnused = 2'd3;
  // slots written per stored row; the length limit never goes past this
  localparam int RowSlots = 6;
  // patterns loaded for the overflow part
  localparam int FillTop = 72;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_item = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_item;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = RegMargin;
  logic [23:0] cfg_data = '0;
  int          pending;
  int          errors;

  // stimulus-side copy of the pattern rows, used only to build sequences
  logic [15:0] row [NumPatterns][MaxSlots];
  int          row_len [NumPatterns];
  int          cur_margin = 200;
  int          cur_trail = 1000;
  int          cur_count = 0;
  int          burst_left = 0;
  int          sent = 0;
  int          stall_tick = 0;

  always #2 clk = ~clk;

  ir_pulse_space_pattern_matcher_top dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  ir_pulse_space_pattern_matcher_checker check (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .pending(pending), .errors(errors)
  );

  // receiver: free, light and heavy stall stretches
  always @(posedge clk) begin
    stall_tick <= stall_tick + 1;
    if (stall_tick % 300 < 80) begin
      out_stall <= 1'b0;
    end else if (stall_tick % 300 < 180) begin
      out_stall <= ($urandom_range(0, 3) == 0);
    end else begin
      out_stall <= ($urandom_range(0, 3) != 0);
    end
  end

  function automatic in_item_t noise();
    in_item_t it;
    it.mode = ModeEvent;
    it.event_kind = 2'($urandom_range(0, 3));
    it.duration = 24'($urandom);
    it.pattern_index = 8'($urandom);
    it.slot_index = 6'($urandom);
    it.table_value = $urandom;
    return it;
  endfunction

  function automatic logic [15:0] pick_dur();
    case ($urandom_range(0, 3))
      0: return 16'd100;
      1: return 16'd560;
      2: return 16'd1690;
      default: return 16'd2400;
    endcase
  endfunction

  task automatic send(in_item_t it);
    int gap;
    bit acc;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = $urandom_range(1, 12);
    end
    burst_left--;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    do begin
      @(negedge clk);
      acc = !in_stall;
      @(posedge clk);
    end while (!acc);
    sent++;
  endtask

  task automatic send_timing(logic [1:0] k, int d);
    in_item_t it;
    it = noise();
    it.event_kind = k;
    it.duration = (d < 0) ? 24'd0 : (d > 24'hFFFFFF) ? 24'hFFFFFF : d[23:0];
    send(it);
  endtask

  task automatic write_slot(int p, int s, logic [15:0] v);
    in_item_t it;
    it = noise();
    it.mode = ModeWrSlot;
    it.pattern_index = 8'(p);
    it.slot_index = 6'(s);
    it.table_value = {16'($urandom), v};
    row[p][s] = v;
    send(it);
  endtask

  task automatic write_code(int p);
    in_item_t it;
    it = noise();
    it.mode = ModeWrCode;
    it.pattern_index = 8'(p);
    it.table_value = $urandom;
    send(it);
  endtask

  task automatic load_row(int p, int len);
    row_len[p] = len;
    for (int s = 0; s < RowSlots; s++) write_slot(p, s, (s < len) ? pick_dur() : 16'd0);
    write_code(p);
  endtask

  // play a stored pattern, pulse first, then close it with a long space or timeout
  task automatic play(int p, bit clean, logic [1:0] tail_kind, int tail_dur);
    int d;
    for (int s = 0; s < row_len[p]; s++) begin
      d = row[p][s];
      if (!clean) begin
        if ($urandom_range(0, 7) == 0) d = $urandom_range(0, 5000);
        else d = d + int'($urandom_range(0, 2 * cur_margin)) - cur_margin;
      end
      send_timing((s % 2 == 0) ? KindPulse : KindSpace, d);
    end
    send_timing(tail_kind, tail_dur);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic configure(int m, int pr, int tr, int ml, int pc);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_index <= RegMargin;    cfg_data <= 24'(m);  @(posedge clk);
    cfg_index <= RegProtocol;  cfg_data <= 24'(pr); @(posedge clk);
    cfg_index <= RegTrail;     cfg_data <= 24'(tr); @(posedge clk);
    cfg_index <= RegMaxLength; cfg_data <= 24'(ml); @(posedge clk);
    cfg_index <= RegPatCount;  cfg_data <= 24'(pc); @(posedge clk);
    cfg_we <= 1'b0;
    cur_margin = m;
    cur_trail = tr;
    cur_count = pc;
  endtask

  task automatic random_action(int npat);
    int r;
    int p;
    in_item_t it;
    r = $urandom_range(0, 9);
    p = (npat > 0) ? $urandom_range(0, npat - 1) : 0;
    if (r < 7) begin
      play(p, ($urandom_range(0, 3) == 0), $urandom_range(0, 1) ? KindSpace : KindTimeout,
           cur_trail + $urandom_range(0, 4000));
    end else if (r == 7) begin
      it = noise();
      if ($urandom_range(0, 5) == 0) it.mode = ModeUnused;
      send(it);
    end else if (r == 8) begin
      write_slot($urandom_range(0, 7), $urandom_range(0, RowSlots - 1),
                 $urandom_range(0, 2) ? pick_dur() : 16'd0);
    end else begin
      write_code($urandom_range(0, 7));
    end
  endtask

  initial begin
    in_item_t it;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    configure(200, 8'hA5, 3000, RowSlots, 8);
    for (int p = 0; p < 7; p++) load_row(p, $urandom_range(1, 4));
    load_row(7, 0);

    // directed items
    it = noise();
    it.mode = ModeUnused;
    send(it);
    it = noise();
    it.event_kind = KindIgnored;
    send(it);
    play(0, 1, KindSpace, cur_trail);
    play(1, 1, KindTimeout, 24'hFFFFFF);
    send_timing(KindPulse, 0);
    send_timing(KindSpace, cur_trail);
    // an empty pattern hits on a closing timeout at the very start
    send_timing(KindTimeout, 24'hFFFFFF);
    send_timing(KindPulse, 24'hFFFFFF);
    send_timing(KindSpace, cur_trail + 1);
    // margin edges on the first slot of pattern 0
    send_timing(KindPulse, row[0][0] + 199);
    send_timing(KindSpace, cur_trail);
    send_timing(KindPulse, row[0][0] + 200);
    send_timing(KindTimeout, cur_trail);
    send_timing(KindSpace, cur_trail - 1);

    while (sent < 100) begin
      if ($urandom_range(0, 40) == 0)
        configure($urandom_range(0, 400), $urandom_range(0, 255), $urandom_range(2900, 6000),
                  $urandom_range(0, RowSlots), $urandom_range(0, 8));
      random_action(8);
    end

    // extremes of the registers
    configure(300, 8'h00, 0, 0, 8);
    repeat (2) random_action(8);
    configure(300, 8'hFF, 0, RowSlots, 8);
    repeat (2) random_action(8);
    configure(300, 8'h5A, 24'hFFFFFF, RowSlots, 0);
    play(2, 1, KindTimeout, 24'hFFFFFF);
    configure(300, 8'h5A, 24'hFFFFFF, RowSlots, 8);
    play(3, 1, KindTimeout, 24'hFFFFFF);
    play(7, 1, KindTimeout, 24'hFFFFFF);

    // many empty patterns: more hits than the block can report
    for (int p = 8; p < FillTop; p++) begin
      write_slot(p, 0, 16'd0);
      write_code(p);
      row_len[p] = 0;
    end
    configure(100, 8'h3C, 3000, 1, FillTop);
    send_timing(KindSpace, 3000);
    send_timing(KindTimeout, 3000);
    repeat (4) random_action(FillTop);
    configure(100, 8'hC3, 3000, 1, FillTop - 12);
    send_timing(KindSpace, 3000);
    repeat (2) random_action(FillTop);

    wait_idle();
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

>>> sim.f
hdl/irpm_pkg.sv
hdl/ir_pulse_space_pattern_matcher_top.sv
hdl/irpm_checker.sv
tb/ir_pulse_space_pattern_matcher_checker.sv
tb/ir_pulse_space_pattern_matcher_top_test.sv
